/* design/vrt_pkg.sv */
// Shared constants, types and tables of the voxel ray caster.
package vrt_pkg;

    localparam int WORLD_DIM_MAX = 64;
    localparam int CW            = $clog2(WORLD_DIM_MAX);
    localparam int CELLS         = WORLD_DIM_MAX * WORLD_DIM_MAX * WORLD_DIM_MAX;
    localparam int ADDR_W        = $clog2(CELLS);
    localparam int DIMC_W        = 9;
    localparam int MAP_W         = 10;
    localparam int T_W           = 25;
    localparam int DIV_NUM_W     = 30;
    localparam int DIV_DEN_W     = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [T_W-1:0] T_NEVER = T_W'(1) << (T_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOG_EN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOG_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOG_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH     = 3'd6;

    // divider operand selects: three normalisations, three cell steps, three first crossings
    localparam logic [3:0] DSEL_NORM0 = 4'd0;
    localparam logic [3:0] DSEL_TDEL0 = 4'd3;
    localparam logic [3:0] DSEL_TMAX0 = 4'd6;
    localparam logic [3:0] DSEL_LAST  = 4'd8;
    localparam logic [3:0] DSEL_FOG   = 4'd9;

    typedef struct packed {
        logic       load;
        logic       wr;
        logic       sq_en;
        logic       sq_first;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_start;
        logic       div_store;
        logic [3:0] div_sel;
        logic       walk_step;
        logic       shade_scale;
        logic       shade_fog;
        logic       shade_final;
        logic       hp_en;
        logic [1:0] axis;
        logic       out_load;
        logic       out_miss;
    } t_dp_cmd;

    typedef struct packed {
        logic sum_zero;
        logic div_done;
        logic walk_end;
        logic walk_oob;
        logic blk_nz;
        logic fog_div;
    } t_dp_sts;

    function automatic logic [8:0] face_factor(input logic [2:0] face);
        logic [8:0] f;
        f = 9'd0;
        unique case (face)
            3'd0:    f = 9'd205;
            3'd1:    f = 9'd154;
            3'd2:    f = 9'd256;
            3'd3:    f = 9'd51;
            3'd4:    f = 9'd230;
            3'd5:    f = 9'd179;
            default: f = 9'd0;
        endcase
        return f;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [CW-1:0] x,
                                                    input logic [CW-1:0] y,
                                                    input logic [CW-1:0] z);
        logic [ADDR_W+CW-1:0] a;
        a = (ADDR_W+CW)'(x) * (ADDR_W+CW)'(WORLD_DIM_MAX) + (ADDR_W+CW)'(y);
        a = a * (ADDR_W+CW)'(WORLD_DIM_MAX) + (ADDR_W+CW)'(z);
        return a[ADDR_W-1:0];
    endfunction

endpackage

/* design/vrt_div.sv */
// Serial restoring divider, one quotient bit per cycle.
module vrt_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [vrt_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [vrt_pkg::DIV_DEN_W-1:0]  i_den,
    output logic [vrt_pkg::DIV_NUM_W-1:0]  o_quo,
    output logic                           o_done
);
    import vrt_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0]   rem_sh;
    logic                 qbit;

    always_comb begin
        rem_sh = {r_rem[DIV_DEN_W-1:0], r_num[DIV_NUM_W-1]};
        qbit   = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= qbit ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_num <= {r_num[DIV_NUM_W-2:0], qbit};
        end
    end

    assign o_quo  = r_num;
    assign o_done = r_done;

endmodule

/* design/vrt_dp.sv */
// Datapath of the voxel ray caster: settings, voxel memory, set-up arithmetic, walk, shading.
module vrt_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vrt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vrt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [5:0]                      i_cell_x,
    input  logic [5:0]                      i_cell_y,
    input  logic [5:0]                      i_cell_z,
    input  logic [7:0]                      i_block_value,
    input  logic [8:0]                      i_light_value,
    input  logic signed [15:0]              i_pos_x,
    input  logic signed [15:0]              i_pos_y,
    input  logic signed [15:0]              i_pos_z,
    input  logic signed [15:0]              i_dir_x,
    input  logic signed [15:0]              i_dir_y,
    input  logic signed [15:0]              i_dir_z,
    input  vrt_pkg::t_dp_cmd                i_cmd,
    output vrt_pkg::t_dp_sts                o_sts,
    output logic                            o_hit,
    output logic [7:0]                      o_hit_block,
    output logic [15:0]                     o_hit_distance,
    output logic [2:0]                      o_hit_face,
    output logic [8:0]                      o_hit_brightness,
    output logic signed [15:0]              o_hit_x,
    output logic signed [15:0]              o_hit_y,
    output logic signed [15:0]              o_hit_z
);
    import vrt_pkg::*;

    typedef enum logic [1:0] {
        FC_ZERO = 2'd0,
        FC_FULL = 2'd1,
        FC_DIV  = 2'd2
    } t_fog_case;

    // settings
    logic [15:0] r_max_dist, r_fog_start, r_fog_end;
    logic        r_fog_en;
    logic [6:0]  r_dim [3];

    // voxel memory, {block, light}
    logic [16:0] r_mem [0:CELLS-1];
    logic [16:0] r_rd;

    logic signed [15:0]      r_pos  [3];
    logic signed [15:0]      r_dir  [3];
    logic [31:0]             r_sum;
    logic [31:0]             r_sq_v;
    logic [17:0]             r_sq_rem;
    logic [15:0]             r_len;
    logic [14:0]             r_nmag [3];
    logic [T_W-1:0]          r_tdel [3];
    logic [T_W-1:0]          r_tmax [3];
    logic signed [MAP_W-1:0] r_map  [3];
    logic [T_W-1:0]          r_dist;
    logic [2:0]              r_face;
    logic [9:0]              r_b1;
    t_fog_case               r_fcase;
    logic [7:0]              r_g;
    logic [8:0]              r_bright;
    logic signed [15:0]      r_hp   [3];

    logic                    r_o_hit;
    logic [7:0]              r_o_block;
    logic [15:0]             r_o_dist;
    logic [2:0]              r_o_face;
    logic [8:0]              r_o_bright;
    logic signed [15:0]      r_o_hp [3];

    // settings port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist  <= 16'd8192;
            r_fog_en    <= 1'b1;
            r_fog_start <= 16'd2560;
            r_fog_end   <= 16'd7680;
            r_dim[0]    <= 7'd64;
            r_dim[1]    <= 7'd64;
            r_dim[2]    <= 7'd64;
        end else if (i_cfg_we) begin
            priority case (i_cfg_index)
                CFG_MAX_DIST:  r_max_dist  <= i_cfg_data;
                CFG_FOG_EN:    r_fog_en    <= i_cfg_data[0];
                CFG_FOG_START: r_fog_start <= i_cfg_data;
                CFG_FOG_END:   r_fog_end   <= i_cfg_data;
                CFG_WIDTH:     r_dim[0]    <= i_cfg_data[6:0];
                CFG_HEIGHT:    r_dim[1]    <= i_cfg_data[6:0];
                CFG_DEPTH:     r_dim[2]    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // per-axis helpers
    logic               neg   [3];
    logic [15:0]        mag   [3];
    logic [8:0]         first [3];
    logic [DIMC_W-1:0]  dim_c [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg[i]   = r_dir[i][15];
            mag[i]   = neg[i] ? 16'(-r_dir[i]) : 16'(r_dir[i]);
            first[i] = neg[i] ? {1'b0, r_pos[i][7:0]} : (9'd256 - {1'b0, r_pos[i][7:0]});
            dim_c[i] = ({2'b0, r_dim[i]} > DIMC_W'(WORLD_DIM_MAX)) ?
                       DIMC_W'(WORLD_DIM_MAX) : {2'b0, r_dim[i]};
        end
    end

    // walk step: pick the nearest boundary, ties to Y over X and Z over both
    logic [1:0]              wa;
    logic signed [MAP_W-1:0] nmap [3];
    logic                    oob;
    logic [ADDR_W-1:0]       rd_addr;
    always_comb begin
        if (r_tmax[0] < r_tmax[1] && r_tmax[0] < r_tmax[2])
            wa = 2'd0;
        else if (r_tmax[1] < r_tmax[2])
            wa = 2'd1;
        else
            wa = 2'd2;
        oob = 1'b0;
        for (int i = 0; i < 3; i++) begin
            nmap[i] = r_map[i];
            if (wa == 2'(i))
                nmap[i] = neg[i] ? (r_map[i] - MAP_W'(1)) : (r_map[i] + MAP_W'(1));
            if (nmap[i][MAP_W-1] || (DIMC_W'(nmap[i]) >= dim_c[i]))
                oob = 1'b1;
        end
        rd_addr = cell_addr(CW'(nmap[0]), CW'(nmap[1]), CW'(nmap[2]));
    end

    // write request address
    logic              wr_ok;
    logic [ADDR_W-1:0] wr_addr;
    always_comb begin
        wr_ok = ({3'b0, i_cell_x} < 9'(WORLD_DIM_MAX)) && ({3'b0, i_cell_y} < 9'(WORLD_DIM_MAX))
             && ({3'b0, i_cell_z} < 9'(WORLD_DIM_MAX));
        wr_addr = cell_addr(CW'(i_cell_x), CW'(i_cell_y), CW'(i_cell_z));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && wr_ok)
            r_mem[wr_addr] <= {i_block_value, i_light_value};
        if (i_cmd.walk_step)
            r_rd <= r_mem[rd_addr];
    end

    // fog case from the distance reached
    logic signed [T_W:0]  fnum;
    logic signed [16:0]   fden;
    logic [T_W-1:0]       an;
    logic [15:0]          ad;
    t_fog_case            fcase;
    always_comb begin
        fnum = $signed({1'b0, r_dist}) - $signed((T_W+1)'(r_fog_start));
        fden = $signed({1'b0, r_fog_end}) - $signed({1'b0, r_fog_start});
        an   = fnum[T_W] ? T_W'(-fnum) : T_W'(fnum);
        ad   = fden[16] ? 16'(-fden) : 16'(fden);
        if (!r_fog_en)
            fcase = FC_ZERO;
        else if (fden == 17'sd0)
            fcase = FC_FULL;
        else if (!((fnum > 0 && fden > 0) || (fnum < 0 && fden < 0)))
            fcase = FC_ZERO;
        else if (an >= T_W'(ad))
            fcase = FC_FULL;
        else
            fcase = FC_DIV;
    end

    // shared divider
    logic [1:0]           da;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] quo;
    logic                 div_done;
    always_comb begin
        if (i_cmd.div_sel < DSEL_TDEL0)
            da = 2'(i_cmd.div_sel - DSEL_NORM0);
        else if (i_cmd.div_sel < DSEL_TMAX0)
            da = 2'(i_cmd.div_sel - DSEL_TDEL0);
        else
            da = 2'(i_cmd.div_sel - DSEL_TMAX0);
        if (i_cmd.div_sel == DSEL_FOG) begin
            div_num = DIV_NUM_W'({an[15:0], 8'd0});
            div_den = ad;
        end else if (i_cmd.div_sel < DSEL_TDEL0) begin
            div_num = DIV_NUM_W'({mag[da], 14'd0});
            div_den = r_len;
        end else if (i_cmd.div_sel < DSEL_TMAX0) begin
            div_num = DIV_NUM_W'(1) << 22;
            div_den = {1'b0, r_nmag[da]};
        end else begin
            div_num = DIV_NUM_W'({first[da], 14'd0});
            div_den = {1'b0, r_nmag[da]};
        end
    end

    vrt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    // arithmetic of the set-up and shading steps
    logic signed [31:0]      sq;
    logic [17:0]             rem_sh;
    logic [17:0]             trial;
    logic [17:0]             lprod;
    logic [8:0]              fval;
    logic [22:0]             gprod;
    logic [18:0]             fprod;
    logic [10:0]             b2;
    logic signed [15:0]      nrm;
    logic signed [41:0]      hprod;
    logic signed [41:0]      hsum;
    logic signed [15:0]      hsat;
    always_comb begin
        sq     = r_dir[i_cmd.axis] * r_dir[i_cmd.axis];
        rem_sh = {r_sq_rem[15:0], r_sq_v[31:30]};
        trial  = {r_len, 2'b01};
        lprod  = r_rd[8:0] * face_factor(r_face);
        unique case (r_fcase)
            FC_FULL: fval = 9'd256;
            FC_DIV:  fval = {1'b0, quo[7:0]};
            default: fval = 9'd0;
        endcase
        // floor(f*4/5) by reciprocal
        gprod = fval * 14'd13108;
        fprod = r_b1 * (9'd256 - {1'b0, r_g});
        b2    = fprod[18:8];
        nrm   = neg[i_cmd.axis] ? -$signed({1'b0, r_nmag[i_cmd.axis]})
                                :  $signed({1'b0, r_nmag[i_cmd.axis]});
        hprod = nrm * $signed({1'b0, r_dist});
        hsum  = 42'(r_pos[i_cmd.axis]) + (hprod >>> 14);
        if (hsum > 42'sd32767)
            hsat = 16'sh7FFF;
        else if (hsum < -42'sd32768)
            hsat = -16'sh8000;
        else
            hsat = 16'(hsum);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos[0] <= i_pos_x;
            r_pos[1] <= i_pos_y;
            r_pos[2] <= i_pos_z;
            r_dir[0] <= i_dir_x;
            r_dir[1] <= i_dir_y;
            r_dir[2] <= i_dir_z;
            r_map[0] <= MAP_W'(i_pos_x >>> 8);
            r_map[1] <= MAP_W'(i_pos_y >>> 8);
            r_map[2] <= MAP_W'(i_pos_z >>> 8);
            r_dist   <= '0;
        end
        if (i_cmd.sq_en)
            r_sum <= i_cmd.sq_first ? 32'(sq) : (r_sum + 32'(sq));
        if (i_cmd.sqrt_init) begin
            r_sq_v   <= r_sum;
            r_sq_rem <= '0;
            r_len    <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sq_v <= {r_sq_v[29:0], 2'b00};
            if (rem_sh >= trial) begin
                r_sq_rem <= rem_sh - trial;
                r_len    <= {r_len[14:0], 1'b1};
            end else begin
                r_sq_rem <= rem_sh;
                r_len    <= {r_len[14:0], 1'b0};
            end
        end
        if (i_cmd.div_store) begin
            if (i_cmd.div_sel < DSEL_TDEL0)
                r_nmag[da] <= quo[14:0];
            else if (i_cmd.div_sel < DSEL_TMAX0)
                r_tdel[da] <= (r_nmag[da] == '0) ? T_NEVER : quo[T_W-1:0];
            else
                r_tmax[da] <= (r_nmag[da] == '0) ? T_NEVER : quo[T_W-1:0];
        end
        if (i_cmd.walk_step) begin
            r_dist     <= r_tmax[wa];
            r_tmax[wa] <= r_tmax[wa] + r_tdel[wa];
            r_map[wa]  <= nmap[wa];
            r_face     <= {wa, ~neg[wa]};
        end
        if (i_cmd.shade_scale) begin
            r_b1    <= lprod[17:8];
            r_fcase <= fcase;
        end
        if (i_cmd.shade_fog)
            r_g <= gprod[21:14];
        if (i_cmd.shade_final) begin
            if (b2 < 11'd51)
                r_bright <= 9'd51;
            else if (b2 > 11'd256)
                r_bright <= 9'd256;
            else
                r_bright <= b2[8:0];
        end
        if (i_cmd.hp_en)
            r_hp[i_cmd.axis] <= hsat;
        if (i_cmd.out_load) begin
            if (i_cmd.out_miss) begin
                r_o_hit    <= 1'b0;
                r_o_block  <= '0;
                r_o_dist   <= r_max_dist;
                r_o_face   <= '0;
                r_o_bright <= '0;
                r_o_hp[0]  <= '0;
                r_o_hp[1]  <= '0;
                r_o_hp[2]  <= '0;
            end else begin
                r_o_hit    <= 1'b1;
                r_o_block  <= r_rd[16:9];
                r_o_dist   <= (r_dist[T_W-1:16] != '0) ? 16'hFFFF : r_dist[15:0];
                r_o_face   <= r_face;
                r_o_bright <= r_bright;
                r_o_hp[0]  <= r_hp[0];
                r_o_hp[1]  <= r_hp[1];
                r_o_hp[2]  <= r_hp[2];
            end
        end
    end

    always_comb begin
        o_sts.sum_zero = (r_sum == '0);
        o_sts.div_done = div_done;
        o_sts.walk_end = (r_dist >= T_W'(r_max_dist));
        o_sts.walk_oob = oob;
        o_sts.blk_nz   = (r_rd[16:9] != '0);
        o_sts.fog_div  = (fcase == FC_DIV);
    end

    assign o_hit            = r_o_hit;
    assign o_hit_block      = r_o_block;
    assign o_hit_distance   = r_o_dist;
    assign o_hit_face       = r_o_face;
    assign o_hit_brightness = r_o_bright;
    assign o_hit_x          = r_o_hp[0];
    assign o_hit_y          = r_o_hp[1];
    assign o_hit_z          = r_o_hp[2];

endmodule

/* design/vrt_ctrl.sv */
// Sequencer of the voxel ray caster: request handshake, set-up steps, walk and shading.
module vrt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_kind,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  vrt_pkg::t_dp_sts i_sts,
    output vrt_pkg::t_dp_cmd o_cmd
);
    import vrt_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_SQ    = 15'b000000000000010,
        S_CHK   = 15'b000000000000100,
        S_SQRT  = 15'b000000000001000,
        S_DIVGO = 15'b000000000010000,
        S_DIVWT = 15'b000000000100000,
        S_WALK  = 15'b000000001000000,
        S_MEM   = 15'b000000010000000,
        S_SCALE = 15'b000000100000000,
        S_FOGGO = 15'b000001000000000,
        S_FOGWT = 15'b000010000000000,
        S_FOG   = 15'b000100000000000,
        S_FINAL = 15'b001000000000000,
        S_HP    = 15'b010000000000000,
        S_OUT   = 15'b100000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       r_miss, n_miss;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_miss  = r_miss;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind) begin
                        o_cmd.load = 1'b1;
                        n_cnt      = '0;
                        n_miss     = 1'b0;
                        n_state    = S_SQ;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            S_SQ: begin
                o_cmd.sq_en    = 1'b1;
                o_cmd.axis     = r_cnt[1:0];
                o_cmd.sq_first = (r_cnt == '0);
                if (r_cnt == 4'd2) begin
                    n_state = S_CHK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CHK: begin
                if (i_sts.sum_zero) begin
                    n_miss  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.sqrt_init = 1'b1;
                    n_cnt           = '0;
                    n_state         = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == 4'd15) begin
                    n_state = S_DIVGO;
                end
            end
            S_DIVGO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = r_cnt;
                n_state         = S_DIVWT;
            end
            S_DIVWT: begin
                o_cmd.div_sel = r_cnt;
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (r_cnt == DSEL_LAST) begin
                        n_state = S_WALK;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_DIVGO;
                    end
                end
            end
            S_WALK: begin
                if (i_sts.walk_end) begin
                    n_miss  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.walk_step = 1'b1;
                    if (i_sts.walk_oob) begin
                        n_miss  = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_MEM;
                    end
                end
            end
            S_MEM: begin
                n_state = i_sts.blk_nz ? S_SCALE : S_WALK;
            end
            S_SCALE: begin
                o_cmd.shade_scale = 1'b1;
                n_state           = i_sts.fog_div ? S_FOGGO : S_FOG;
            end
            S_FOGGO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_FOG;
                n_state         = S_FOGWT;
            end
            S_FOGWT: begin
                o_cmd.div_sel = DSEL_FOG;
                if (i_sts.div_done) begin
                    n_state = S_FOG;
                end
            end
            S_FOG: begin
                o_cmd.shade_fog = 1'b1;
                n_state         = S_FINAL;
            end
            S_FINAL: begin
                o_cmd.shade_final = 1'b1;
                n_cnt             = '0;
                n_state           = S_HP;
            end
            S_HP: begin
                o_cmd.hp_en = 1'b1;
                o_cmd.axis  = r_cnt[1:0];
                if (r_cnt == 4'd2) begin
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_miss = r_miss;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load)
            n_out_valid = 1'b1;
        else if (!i_out_stall)
            n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_miss      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_miss      <= n_miss;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* design/voxel_ray_traversal.sv */
// Top level of the voxel ray caster.
// A write request stores one cell. A cast request squares the direction with one
// multiplier, one axis at a time, takes the integer square root one bit a cycle,
// and then runs nine divisions on the shared serial divider for the unit
// direction, the per-cell step and the first crossing of each axis. The walk then
// steps from cell to cell, each step through a walk state and a memory state, as
// the read of the voxel memory is registered; a hit then runs the shading steps,
// with a division for the fog factor when it needs one. Only one cast is in
// flight; a finished result waits in the output register while the next request is
// taken. The voxel memory is not cleared: load every cell before casting.
module voxel_ray_traversal (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_kind,
    input  logic [5:0]                      i_cell_x,
    input  logic [5:0]                      i_cell_y,
    input  logic [5:0]                      i_cell_z,
    input  logic [7:0]                      i_block_value,
    input  logic [8:0]                      i_light_value,
    input  logic signed [15:0]              i_pos_x,
    input  logic signed [15:0]              i_pos_y,
    input  logic signed [15:0]              i_pos_z,
    input  logic signed [15:0]              i_dir_x,
    input  logic signed [15:0]              i_dir_y,
    input  logic signed [15:0]              i_dir_z,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_hit,
    output logic [7:0]                      o_hit_block,
    output logic [15:0]                     o_hit_distance,
    output logic [2:0]                      o_hit_face,
    output logic [8:0]                      o_hit_brightness,
    output logic signed [15:0]              o_hit_x,
    output logic signed [15:0]              o_hit_y,
    output logic signed [15:0]              o_hit_z,
    input  logic                            i_cfg_we,
    input  logic [vrt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vrt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import vrt_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    vrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    vrt_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cell_x         (i_cell_x),
        .i_cell_y         (i_cell_y),
        .i_cell_z         (i_cell_z),
        .i_block_value    (i_block_value),
        .i_light_value    (i_light_value),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_dir_x          (i_dir_x),
        .i_dir_y          (i_dir_y),
        .i_dir_z          (i_dir_z),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_hit            (o_hit),
        .o_hit_block      (o_hit_block),
        .o_hit_distance   (o_hit_distance),
        .o_hit_face       (o_hit_face),
        .o_hit_brightness (o_hit_brightness),
        .o_hit_x          (o_hit_x),
        .o_hit_y          (o_hit_y),
        .o_hit_z          (o_hit_z)
    );

`ifndef SYNTHESIS
    a_hit_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (o_hit_block != 8'd0))
        else $error("hit result with air block");

    a_hit_bright: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (o_hit_brightness >= 9'd51 && o_hit_brightness <= 9'd256))
        else $error("hit brightness out of range");

    a_hit_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (o_hit_face <= 3'd5))
        else $error("hit face out of range");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_hit_block == 8'd0 && o_hit_brightness == 9'd0
                                     && o_hit_face == 3'd0 && o_hit_x == 16'sd0))
        else $error("miss result not cleared");
`endif

endmodule

/* verif/tb_voxel_ray_traversal.sv */
// Self-checking testbench for the voxel ray caster: fills the voxel store, then casts rays.
`timescale 1ns / 100ps

module tb_voxel_ray_traversal;
    import vrt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 20000;
    localparam int LOAD_DIM = 8;
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [5:0]        cx, cy, cz;
        logic [7:0]        blk;
        logic [8:0]        light;
        logic signed [15:0] px, py, pz;
        logic signed [15:0] dx, dy, dz;
    } t_ray_req;

    typedef struct packed {
        logic              hit;
        logic [7:0]        blk;
        logic [15:0]       hdist;
        logic [2:0]        face;
        logic [8:0]        bright;
        logic signed [15:0] x, y, z;
    } t_ray_hit;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_kind = 1'b0;
    logic [5:0] i_cell_x = '0, i_cell_y = '0, i_cell_z = '0;
    logic [7:0] i_block_value = '0;
    logic [8:0] i_light_value = '0;
    logic signed [15:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [15:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic o_hit;
    logic [7:0] o_hit_block;
    logic [15:0] o_hit_distance;
    logic [2:0] o_hit_face;
    logic [8:0] o_hit_brightness;
    logic signed [15:0] o_hit_x, o_hit_y, o_hit_z;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    voxel_ray_traversal u_dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow of the block state
    logic [7:0] blk_mem [CELLS];
    logic [8:0] light_mem [CELLS];
    int max_dist = 8192, fog_on = 1, fog_lo = 2560, fog_hi = 7680;
    int dim_w = 64, dim_h = 64, dim_d = 64;
    int shade_tab [6] = '{205, 154, 256, 51, 230, 179};

    t_ray_req request_q [$];
    t_ray_hit hit_q [$];
    t_ray_req cur_req;
    bit gaps_on = 1'b0;
    int gap_left = 0, stall_left = 0;
    int errors = 0, casts_done = 0, hits_seen = 0, idle_cycles = 0;

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_s16(input longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic void trace_ray(input t_ray_req r);
        longint p[3], d[3], n[3], tm[3], td[3], m[3], st[3], dims[3];
        longint sum, len, mag, nn, frac, walk_t, num, den, f, b;
        int ax, face, a;
        t_ray_hit res;
        res = '0;
        res.hdist = max_dist[15:0];
        dims[0] = dim_w > 64 ? 64 : dim_w;
        dims[1] = dim_h > 64 ? 64 : dim_h;
        dims[2] = dim_d > 64 ? 64 : dim_d;
        p[0] = r.px; p[1] = r.py; p[2] = r.pz;
        d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
        sum = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        walk_t = 0;
        if (sum != 0) begin
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++) begin
                mag = d[i] < 0 ? -d[i] : d[i];
                nn = (mag * 16384) / len;
                frac = p[i] & 255;
                n[i] = d[i] < 0 ? -nn : nn;
                m[i] = (p[i] - frac) / 256;
                if (nn == 0) begin
                    st[i] = 0;
                    td[i] = 64'd1 << 40;
                    tm[i] = 64'd1 << 40;
                end else begin
                    st[i] = d[i] < 0 ? -1 : 1;
                    td[i] = 4194304 / nn;
                    tm[i] = ((d[i] < 0 ? frac : 256 - frac) * 16384) / nn;
                end
            end
            while (walk_t < max_dist) begin
                // ties go to Y over X, and to Z over both
                if (tm[0] < tm[1] && tm[0] < tm[2]) ax = 0;
                else if (tm[1] < tm[2]) ax = 1;
                else ax = 2;
                walk_t = tm[ax];
                tm[ax] += td[ax];
                m[ax] += st[ax];
                face = ax * 2 + (st[ax] > 0 ? 1 : 0);
                if (m[0] < 0 || m[1] < 0 || m[2] < 0 || m[0] >= dims[0] ||
                    m[1] >= dims[1] || m[2] >= dims[2])
                    break;
                a = int'((m[0] * 64 + m[1]) * 64 + m[2]);
                if (blk_mem[a] == 0) continue;
                b = (longint'(light_mem[a]) * shade_tab[face]) >> 8;
                if (fog_on != 0) begin
                    num = walk_t - fog_lo;
                    den = longint'(fog_hi) - fog_lo;
                    if (den == 0) begin
                        f = 256;
                    end else if ((num > 0 && den > 0) || (num < 0 && den < 0)) begin
                        f = ((num < 0 ? -num : num) * 256) / (den < 0 ? -den : den);
                        if (f > 256) f = 256;
                    end else begin
                        f = 0;
                    end
                    b = (b * (256 - (f * 4) / 5)) >> 8;
                end
                if (b < 51) b = 51;
                if (b > 256) b = 256;
                res.hit = 1'b1;
                res.blk = blk_mem[a];
                res.hdist = walk_t > 65535 ? 16'hFFFF : walk_t[15:0];
                res.face = face[2:0];
                res.bright = b[8:0];
                res.x = sat_s16(p[0] + ((n[0] * walk_t) >>> 14));
                res.y = sat_s16(p[1] + ((n[1] * walk_t) >>> 14));
                res.z = sat_s16(p[2] + ((n[2] * walk_t) >>> 14));
                break;
            end
        end
        hit_q.push_back(res);
    endfunction

    function automatic void apply_request(input t_ray_req r);
        if (r.kind == KIND_WRITE) begin
            blk_mem[(int'(r.cx) * 64 + r.cy) * 64 + r.cz] = r.blk;
            light_mem[(int'(r.cx) * 64 + r.cy) * 64 + r.cz] = r.light;
        end else begin
            trace_ray(r);
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) apply_request(cur_req);
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    cur_req = request_q.pop_front();
                    i_kind <= cur_req.kind;
                    i_cell_x <= cur_req.cx;
                    i_cell_y <= cur_req.cy;
                    i_cell_z <= cur_req.cz;
                    i_block_value <= cur_req.blk;
                    i_light_value <= cur_req.light;
                    i_pos_x <= cur_req.px;
                    i_pos_y <= cur_req.py;
                    i_pos_z <= cur_req.pz;
                    i_dir_x <= cur_req.dx;
                    i_dir_y <= cur_req.dy;
                    i_dir_z <= cur_req.dz;
                    i_in_valid <= 1'b1;
                    if (gaps_on && $urandom_range(0, 9) == 0) gap_left <= $urandom_range(1, 16);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endfunction

    // monitor
    always @(posedge i_clk) begin
        t_ray_hit e;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (hit_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got hit=%0d dist=%0d",
                             $time, o_hit, o_hit_distance);
                end else begin
                    e = hit_q.pop_front();
                    casts_done++;
                    if (e.hit) hits_seen++;
                    check_field("hit", e.hit, o_hit);
                    check_field("hit_block", e.blk, o_hit_block);
                    check_field("hit_distance", e.hdist, o_hit_distance);
                    check_field("hit_face", e.face, o_hit_face);
                    check_field("hit_brightness", e.bright, o_hit_brightness);
                    check_field("hit_x", e.x, o_hit_x);
                    check_field("hit_y", e.y, o_hit_y);
                    check_field("hit_z", e.z, o_hit_z);
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(0, 15);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", idle_cycles);
            $display("FAIL");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[15:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_DIST:  max_dist = val & 16'hFFFF;
            CFG_FOG_EN:    fog_on = val & 1;
            CFG_FOG_START: fog_lo = val & 16'hFFFF;
            CFG_FOG_END:   fog_hi = val & 16'hFFFF;
            CFG_WIDTH:     dim_w = val & 8'h7F;
            CFG_HEIGHT:    dim_h = val & 8'h7F;
            CFG_DEPTH:     dim_d = val & 8'h7F;
            default: ;
        endcase
    endtask

    task automatic set_world(input int md, input int fe, input int fs, input int fh,
                             input int w, input int h, input int dp);
        cfg_write(CFG_MAX_DIST, md);
        cfg_write(CFG_FOG_EN, fe);
        cfg_write(CFG_FOG_START, fs);
        cfg_write(CFG_FOG_END, fh);
        cfg_write(CFG_WIDTH, w);
        cfg_write(CFG_HEIGHT, h);
        cfg_write(CFG_DEPTH, dp);
    endtask

    // hold until every request is taken and every result has come back
    task automatic drain();
        do @(posedge i_clk);
        while (request_q.size() != 0 || i_in_valid || hit_q.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_ray_req write_req(input int x, input int y, input int z,
                                           input int b, input int l);
        t_ray_req r;
        r = '0;
        r.kind = KIND_WRITE;
        r.cx = 6'(x); r.cy = 6'(y); r.cz = 6'(z);
        r.blk = 8'(b); r.light = 9'(l);
        return r;
    endfunction

    function automatic t_ray_req cast_req(input int px, input int py, input int pz,
                                          input int dx, input int dy, input int dz);
        t_ray_req r;
        r = '0;
        r.kind = KIND_CAST;
        r.px = 16'(px); r.py = 16'(py); r.pz = 16'(pz);
        r.dx = 16'(dx); r.dy = 16'(dy); r.dz = 16'(dz);
        return r;
    endfunction

    function automatic int rand_pos(input int dim);
        int de;
        de = dim > 64 ? 64 : (dim < 1 ? 64 : dim);
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 65535);
        return $urandom_range(0, de * 256 - 1);
    endfunction

    function automatic int rand_dir();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return $urandom_range(0, 31) - 16;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic t_ray_req rand_req();
        t_ray_req r;
        r = '0;
        if ($urandom_range(0, 9) < 3) begin
            r.kind = KIND_WRITE;
            r.cx = 6'($urandom);
            r.cy = 6'($urandom);
            r.cz = 6'($urandom);
            r.blk = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
            r.light = ($urandom_range(0, 4) != 0) ? 9'($urandom_range(0, 256)) : 9'($urandom);
        end else begin
            r.kind = KIND_CAST;
            r.px = 16'(rand_pos(dim_w));
            r.py = 16'(rand_pos(dim_h));
            r.pz = 16'(rand_pos(dim_d));
            r.dx = 16'(rand_dir());
            r.dy = 16'(rand_dir());
            r.dz = 16'(rand_dir());
        end
        return r;
    endfunction

    task automatic run_random(input int count);
        repeat (count) request_q.push_back(rand_req());
        drain();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // keep every walk inside the loaded corner of the store
        cfg_write(CFG_WIDTH, LOAD_DIM);
        cfg_write(CFG_HEIGHT, LOAD_DIM);
        cfg_write(CFG_DEPTH, LOAD_DIM);

        // load every cell in use, sparse solid blocks
        for (int x = 0; x < LOAD_DIM; x++)
            for (int y = 0; y < LOAD_DIM; y++)
                for (int z = 0; z < LOAD_DIM; z++)
                    request_q.push_back(write_req(x, y, z,
                        ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : 0,
                        $urandom_range(0, 256)));
        drain();

        // directed: axis walks, ties, extremes, bright light, zero direction
        request_q.push_back(write_req(4, 4, 7, 255, 511));
        request_q.push_back(write_req(4, 7, 4, 1, 256));
        request_q.push_back(write_req(7, 4, 4, 7, 0));
        request_q.push_back(write_req(4, 4, 1, 9, 300));
        request_q.push_back(write_req(5, 5, 5, 3, 200));
        request_q.push_back(write_req(7, 7, 7, 0, 511));
        request_q.push_back(write_req(0, 0, 0, 128, 256));
        request_q.push_back(cast_req(1152, 1152, 1152, 0, 0, 16384));
        request_q.push_back(cast_req(1152, 1152, 1152, 0, 0, -16384));
        request_q.push_back(cast_req(1152, 1152, 1152, 0, 16384, 0));
        request_q.push_back(cast_req(1152, 1152, 1152, 32767, 0, 0));
        request_q.push_back(cast_req(1152, 1152, 1152, 0, 0, 0));
        request_q.push_back(cast_req(1152, 1152, 1152, 5000, 5000, 5000));
        request_q.push_back(cast_req(1280, 1280, 1280, -8000, -8000, -8000));
        request_q.push_back(cast_req(1280, 1280, 1280, 8000, 8000, 0));
        request_q.push_back(cast_req(32767, 32767, 32767, -32768, -32768, -32768));
        request_q.push_back(cast_req(-32768, -32768, -32768, 32767, 32767, 32767));
        request_q.push_back(cast_req(128, 128, 128, -32768, 1, 0));
        request_q.push_back(cast_req(16383, 16383, 16383, 1, -1, 1));
        request_q.push_back(cast_req(200, 200, 200, 1, 1, 1));
        drain();

        gaps_on = 1'b1;
        run_random(300);
        set_world(65535, 0, 0, 65535, LOAD_DIM, LOAD_DIM, LOAD_DIM);
        run_random(300);
        set_world(0, 1, 100, 100, 1, 64, 127);
        run_random(60);
        set_world(3000, 1, 5000, 1000, LOAD_DIM, 5, 7);
        run_random(300);
        set_world(65535, 1, 0, 0, 0, 64, 64);
        run_random(60);
        set_world(12000, 1, 1024, 4000, LOAD_DIM, LOAD_DIM, LOAD_DIM);
        cfg_write(CFG_UNUSED, 16'hFFFF);
        gaps_on = 1'b0;
        run_random(300);
        repeat (100) @(posedge i_clk);

        $display("Loaded %0d cells, then checked %0d casts (%0d hits) over six settings",
                 LOAD_DIM * LOAD_DIM * LOAD_DIM, casts_done, hits_seen);
        $display("of distance limit, fog and world size, with random gaps and stalls.");
        if (errors == 0 && hit_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d results never arrived", errors, hit_q.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/vrt_pkg.sv
design/vrt_div.sv
design/vrt_dp.sv
design/vrt_ctrl.sv
design/voxel_ray_traversal.sv
verif/tb_voxel_ray_traversal.sv
